FILE: hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // Store depth and the widths that follow from it
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Request codes
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_FIND   = 2'd2
    } req_t;

    // One request item
    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] item_value;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic               hit;
        logic [3:0]         position;
        logic               overflow;
        logic signed [31:0] head_value;
        logic               head_valid;
        logic [4:0]         entry_count;
    } out_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/spq_cells.sv
// Sorted cell array: parallel compare, one-step shift and result build.
`timescale 1ns / 1ps
`default_nettype none

module spq_cells (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              commit,
    input  wire spq_pkg::in_item_t req,
    output spq_pkg::out_item_t     result
);

    logic signed [31:0]             cells_reg [spq_pkg::DEPTH];
    logic signed [31:0]             cells_next [spq_pkg::DEPTH];
    logic signed [31:0]             shift_up [spq_pkg::DEPTH];
    logic signed [31:0]             shift_down [spq_pkg::DEPTH];
    logic [spq_pkg::CNT_W-1:0]      count_reg;
    logic [spq_pkg::CNT_W-1:0]      count_next;
    logic [spq_pkg::DEPTH-1:0]      ge_vec;
    logic [spq_pkg::DEPTH-1:0]      gt_vec;
    logic [spq_pkg::DEPTH-1:0]      eq_vec;
    logic [spq_pkg::CNT_W-1:0]      n_ge;
    logic [spq_pkg::CNT_W-1:0]      n_gt;
    logic                           full;
    logic                           found;
    logic                           do_ins;
    logic                           do_rem;
    logic                           res_hit;
    logic [3:0]                     res_position;
    logic                           res_overflow;
    logic signed [31:0]             res_head_value;
    logic                           res_head_valid;
    logic [4:0]                     res_entry_count;

    // Neighbor views of the array for the shift in either direction
    always_comb
    begin
        shift_up[0] = cells_reg[0];
        for (int i = 1; i < spq_pkg::DEPTH; i++)
        begin
            shift_up[i] = cells_reg[i-1];
        end
        shift_down[spq_pkg::DEPTH-1] = cells_reg[spq_pkg::DEPTH-1];
        for (int i = 0; i < spq_pkg::DEPTH - 1; i++)
        begin
            shift_down[i] = cells_reg[i+1];
        end
    end

    // Compare every occupied cell against the key at once
    always_comb
    begin
        for (int i = 0; i < spq_pkg::DEPTH; i++)
        begin
            ge_vec[i] = (spq_pkg::CNT_W'(i) < count_reg) && (cells_reg[i] >= req.item_value);
            gt_vec[i] = (spq_pkg::CNT_W'(i) < count_reg) && (cells_reg[i] > req.item_value);
            eq_vec[i] = (spq_pkg::CNT_W'(i) < count_reg) && (cells_reg[i] == req.item_value);
        end
        // Sorted descending, so both greater masks are prefixes
        n_ge  = spq_pkg::CNT_W'($countones(ge_vec));
        n_gt  = spq_pkg::CNT_W'($countones(gt_vec));
        full  = (count_reg == spq_pkg::CNT_W'(spq_pkg::DEPTH));
        found = |eq_vec;
    end

    // Decode the request and build the result fields
    always_comb
    begin
        do_ins       = 1'b0;
        do_rem       = 1'b0;
        res_hit      = 1'b0;
        res_position = 4'd0;
        res_overflow = 1'b0;
        case (req.req_type)
            spq_pkg::REQ_INSERT:
            begin
                if (full)
                begin
                    res_overflow = 1'b1;
                end
                else
                begin
                    do_ins       = 1'b1;
                    res_hit      = 1'b1;
                    res_position = n_ge[3:0];
                end
            end
            spq_pkg::REQ_REMOVE:
            begin
                if (found)
                begin
                    do_rem       = 1'b1;
                    res_hit      = 1'b1;
                    res_position = n_gt[3:0];
                end
            end
            spq_pkg::REQ_FIND:
            begin
                if (found)
                begin
                    res_hit      = 1'b1;
                    res_position = n_gt[3:0];
                end
            end
            default:
            begin
                res_hit = 1'b0;
            end
        endcase
    end

    // Open a slot for an insert or close the gap of a remove
    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rem)
        begin
            count_next = count_reg - 1'b1;
        end
        for (int i = 0; i < spq_pkg::DEPTH; i++)
        begin
            cells_next[i] = cells_reg[i];
            if (do_ins)
            begin
                if (spq_pkg::CNT_W'(i) == n_ge)
                begin
                    cells_next[i] = req.item_value;
                end
                else if (spq_pkg::CNT_W'(i) > n_ge)
                begin
                    cells_next[i] = shift_up[i];
                end
            end
            else if (do_rem)
            begin
                if (spq_pkg::CNT_W'(i) >= n_gt)
                begin
                    cells_next[i] = shift_down[i];
                end
            end
        end
        res_head_valid  = (count_next != '0);
        res_head_value  = (count_next != '0) ? cells_next[0] : 32'sd0;
        res_entry_count = 5'(count_next);
    end

    // Pack the result fields
    assign result = '{
        hit:         res_hit,
        position:    res_position,
        overflow:    res_overflow,
        head_value:  res_head_value,
        head_valid:  res_head_valid,
        entry_count: res_entry_count
    };

    // Hold the cell contents
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            cells_reg <= cells_next;
        end
    end

    // Hold the fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (commit)
        begin
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
        else $error("fill count above depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        commit && (req.req_type == spq_pkg::REQ_INSERT) && !full
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted insert did not grow the store");

    a_find_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        commit && (req.req_type == spq_pkg::REQ_FIND)
        |=> count_reg == $past(count_reg))
        else $error("find changed the fill count");

    a_overflow_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_overflow |-> full && !res_hit)
        else $error("overflow without a full store");

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue with its input and result registers.
`timescale 1ns / 1ps
`default_nettype none

// Sorted priority queue of up to 16 signed 32-bit values, largest at the
// head. Each request (insert, remove first equal, find) gives exactly one
// result carrying hit, position, overflow and the head value, head valid
// flag and entry count after the request. A request is registered on entry,
// then resolved by a parallel compare of all cells against the key and a
// one-step shift of the array, and the result is registered on exit; one
// request per cycle is sustained as long as results are taken. A full store
// refuses an insert and flags overflow; an equal value is placed after its
// equals.

module sorted_priority_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire spq_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output spq_pkg::out_item_t     out_data
);

    logic                in_valid_reg;
    spq_pkg::in_item_t   in_data_reg;
    logic                out_valid_reg;
    spq_pkg::out_item_t  out_data_reg;
    spq_pkg::out_item_t  result;
    logic                advance;
    logic                in_xfer;

    // Move the held request on when the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    spq_cells u_cells (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (advance),
        .req    (in_data_reg),
        .result (result)
    );

    // Input register: load on transfer, drop when advanced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_data_reg <= in_data;
        end
    end

    // Result register: load on advance, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: test/spq_checker.sv
// Checker that predicts and compares every result of the sorted priority queue.
`timescale 1ns / 1ps

module spq_checker
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_data,
    output int        fail_count,
    output int        outstanding
);

    // Shadow copy of the sorted store, largest value at index 0
    logic signed [31:0] shadow_cells [DEPTH];
    int                 shadow_fill;
    int                 mismatches;
    out_item_t          awaited_results [$];

    // Apply one request to the shadow store and build the result it gives
    function automatic out_item_t apply_request(input in_item_t req);
        out_item_t          res;
        logic signed [31:0] key;
        int                 spot;
        bit                 found;
        res   = '0;
        key   = req.item_value;
        spot  = 0;
        found = 1'b0;

        // Locate the first equal entry for remove and find
        if (req.req_type == REQ_REMOVE || req.req_type == REQ_FIND) begin
            for (int i = 0; i < shadow_fill; i++) begin
                if (!found && shadow_cells[i] == key) begin
                    found = 1'b1;
                    spot  = i;
                end
            end
        end

        case (req.req_type)
            REQ_INSERT:
            begin
                if (shadow_fill >= DEPTH) begin
                    res.overflow = 1'b1;
                end
                else begin
                    // Place after every entry greater than or equal to the key
                    while (spot < shadow_fill && shadow_cells[spot] >= key)
                        spot++;
                    for (int i = shadow_fill; i > spot; i--)
                        shadow_cells[i] = shadow_cells[i - 1];
                    shadow_cells[spot] = key;
                    shadow_fill++;
                    res.hit      = 1'b1;
                    res.position = 4'(spot);
                end
            end
            REQ_REMOVE:
            begin
                if (found) begin
                    // Close the gap left by the removed entry
                    for (int i = spot; i + 1 < shadow_fill; i++)
                        shadow_cells[i] = shadow_cells[i + 1];
                    shadow_fill--;
                    res.hit      = 1'b1;
                    res.position = 4'(spot);
                end
            end
            REQ_FIND:
            begin
                if (found) begin
                    res.hit      = 1'b1;
                    res.position = 4'(spot);
                end
            end
            default:
            begin
                // Unused request code leaves the store alone
            end
        endcase

        res.head_valid  = (shadow_fill > 0);
        res.head_value  = (shadow_fill > 0) ? shadow_cells[0] : '0;
        res.entry_count = 5'(shadow_fill);
        return res;
    endfunction

    // Report one field that differs from its prediction
    function automatic void check_field(input string name, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Track both channels: check the result transfer first, then predict the new request
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n) begin
            shadow_fill = 0;
            mismatches  = 0;
            awaited_results.delete();
        end
        else begin
            if (out_valid && !out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer with no result awaited");
                    mismatches++;
                end
                else begin
                    want = awaited_results.pop_front();
                    check_field("hit", want.hit, out_data.hit);
                    check_field("position", want.position, out_data.position);
                    check_field("overflow", want.overflow, out_data.overflow);
                    check_field("head_value", $signed(want.head_value),
                                $signed(out_data.head_value));
                    check_field("head_valid", want.head_valid, out_data.head_valid);
                    check_field("entry_count", want.entry_count, out_data.entry_count);
                end
            end
            if (in_valid && !in_stall)
                awaited_results.push_back(apply_request(in_data));
        end
        fail_count  <= mismatches;
        outstanding <= awaited_results.size();
    end

endmodule

FILE: test/tb_top.sv
// Top of the sorted priority queue testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import spq_pkg::*;

    localparam logic [1:0]         REQ_UNUSED     = 2'd3;
    localparam logic signed [31:0] VAL_MAX        = 32'sh7fff_ffff;
    localparam logic signed [31:0] VAL_MIN        = 32'sh8000_0000;
    localparam int                 RESET_CYCLES   = 11;
    localparam int                 HOLD_CYCLES    = 80;
    localparam int                 DRAIN_CYCLES   = 8;
    localparam int                 WATCHDOG_LIMIT = 2000;
    localparam int                 PHASE_ITEMS    = 180;
    localparam int                 NUM_PHASES     = 8;

    typedef enum int {MIX_FILL, MIX_EVEN, MIX_DRAIN} mix_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    int        fail_count;
    int        outstanding;
    logic      idle_on   = 1'b1;
    logic      rx_hold   = 1'b0;
    int        quiet_cycles = 0;

    sorted_priority_queue uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    spq_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Free-running clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Offer one request, idling at random first, and hold it until the transfer
    task automatic issue(input logic [1:0] kind, input logic signed [31:0] value);
        while (idle_on && $urandom_range(99) < 35) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_data  <= '{req_type: kind, item_value: value};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Draw a value: mostly a narrow band so that equal keys recur
    function automatic logic signed [31:0] pick_value();
        int roll;
        int band;
        roll = $urandom_range(99);
        band = $urandom_range(8);
        if (roll < 60)
            return band - 4;
        if (roll < 70) begin
            case ($urandom_range(4))
                0: return VAL_MAX;
                1: return VAL_MIN;
                2: return 0;
                3: return -1;
                default: return 1;
            endcase
        end
        return $urandom();
    endfunction

    // Draw a request code weighted by the phase mix
    function automatic logic [1:0] pick_kind(input mix_t mix);
        int roll;
        int ins_pct;
        int rem_pct;
        roll    = $urandom_range(99);
        ins_pct = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 20 : 45;
        rem_pct = (mix == MIX_FILL) ? 12 : (mix == MIX_DRAIN) ? 55 : 30;
        if (roll < ins_pct)
            return REQ_INSERT;
        if (roll < ins_pct + rem_pct)
            return REQ_REMOVE;
        if (roll < 95)
            return REQ_FIND;
        return REQ_UNUSED;
    endfunction

    // Result side: random stalls, with one long hold-off on request
    initial
    begin
        forever begin
            @(posedge clk);
            if (rx_hold) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
            else begin
                out_stall <= idle_on && ($urandom_range(99) < 35);
            end
        end
    end

    // Stop the run when no transfer happens for too long
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // Reset, directed requests, random phases, then drain and report
    initial
    begin
        mix_t mix;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty store: misses, and the unused code
        issue(REQ_FIND, 0);
        issue(REQ_REMOVE, VAL_MIN);
        issue(REQ_UNUSED, VAL_MAX);

        // Extremes, equal values, and a value equal to the tail
        issue(REQ_INSERT, 0);
        issue(REQ_INSERT, VAL_MAX);
        issue(REQ_INSERT, VAL_MIN);
        issue(REQ_INSERT, 0);
        issue(REQ_INSERT, VAL_MIN);
        issue(REQ_INSERT, -1);

        // Hits at head, middle and tail, one miss, and the unused code
        issue(REQ_FIND, VAL_MAX);
        issue(REQ_FIND, 0);
        issue(REQ_FIND, VAL_MIN);
        issue(REQ_FIND, 7);
        issue(REQ_UNUSED, 0);

        // Remove down to an empty store, with a miss along the way
        issue(REQ_REMOVE, 0);
        issue(REQ_REMOVE, 42);
        issue(REQ_REMOVE, VAL_MIN);
        issue(REQ_REMOVE, VAL_MAX);
        issue(REQ_REMOVE, -1);
        issue(REQ_REMOVE, 0);
        issue(REQ_REMOVE, VAL_MIN);
        issue(REQ_FIND, VAL_MIN);

        // Random phases; fill phases run into the full store
        for (int p = 0; p < NUM_PHASES; p++) begin
            mix = mix_t'(p % 3);
            idle_on <= (p != 4);
            if (p == 3)
                rx_hold <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                issue(pick_kind(mix), pick_value());
            // Pause the requests until every result is back
            if (p == 2) begin
                in_valid <= 1'b0;
                do @(posedge clk); while (outstanding != 0);
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
